/* rtl/core/aa2rm_pkg.sv */
// ----------------------------------------------------------------------------
// aa2rm_pkg: shared types, constants and helpers
// Fixed-point formats, the CORDIC arctangent table, the pipeline payload
// structs and the rounding product used across the rotation pipeline.
// ----------------------------------------------------------------------------
package aa2rm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TW        = 20;               // twist component width
  localparam int SW        = 24;               // translation width
  localparam int MW        = 18;               // matrix entry width
  localparam int IN_W      = 136;              // 132 payload bits, byte padded
  localparam int OUT_W     = 240;              // 234 payload bits, byte padded

  localparam int ONE_I     = 1 << FRAC_BITS;
  localparam int THR_RAW   = (ONE_I + 5000) / 10000;
  localparam int THR_I     = (THR_RAW < 1) ? 1 : THR_RAW;
  localparam int ABS_W     = TW + 2;
  localparam logic [ABS_W-1:0] THR = ABS_W'(THR_I);

  // square root: one result bit per cell
  localparam int SQ_W      = 2 * TW + 1;
  localparam int NSQ       = TW;
  localparam int SQE_W     = $clog2(SQ_W);
  localparam int TH_W      = TW + 1;

  // axis division: one quotient bit per cell
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int AX_W      = Q_W + 1;
  localparam int NUM_W     = TW + FRAC_BITS + 1;
  localparam int NDIV      = Q_W;
  localparam int DSH_W     = $clog2(NDIV);

  // angle reduction and CORDIC, Q30 angles
  localparam int ANG_W     = 36;
  localparam int XY_W      = 34;
  localparam int NCOR      = 30;
  localparam int CSH_W     = $clog2(NCOR);
  localparam int CS_SH     = 30 - FRAC_BITS;
  localparam logic signed [ANG_W-1:0] TWO_PI  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] PI_Q30  = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI = 36'sd1686629713;
  localparam logic signed [XY_W-1:0]  GAIN    = 34'sd652032874;

  localparam logic [31:0] ATAN [0:NCOR-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  // products
  localparam int P_W = 24;
  localparam logic signed [P_W-1:0]   ONE_P   = P_W'(ONE_I);
  localparam logic signed [2*P_W-1:0] RND_P   = (2*P_W)'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic                vld;
    logic                tiny;
    logic [2:0][TW-1:0]  v;
    logic [2:0][SW-1:0]  p;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [SQ_W-1:0]   n;
    logic [SQ_W-1:0]   r;
  } sqrt_t;

  typedef struct packed {
    side_t                 side;
    logic [TH_W-1:0]       theta;
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][Q_W-1:0]   q;
  } div_t;

  typedef struct packed {
    side_t                side;
    logic [2:0][AX_W-1:0] ax;
    logic signed [ANG_W-1:0] a;
    logic                 flip;
  } ang_t;

  typedef struct packed {
    side_t                   side;
    logic [2:0][AX_W-1:0]    ax;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic                    flip;
  } cor_t;

  typedef struct packed {
    logic               vld;
    logic [8:0][MW-1:0] r;
    logic [2:0][SW-1:0] p;
  } res_t;

  function automatic logic signed [P_W-1:0] mulq(input logic signed [P_W-1:0] a,
                                                 input logic signed [P_W-1:0] b);
    logic signed [2*P_W-1:0] prod;
    prod = (2*P_W)'(a) * (2*P_W)'(b);
    prod = prod + RND_P;
    return P_W'(prod >>> FRAC_BITS);
  endfunction

  function automatic logic [MW-1:0] sat1(input logic signed [P_W-1:0] v);
    if (v > ONE_P) begin
      return MW'(ONE_P);
    end else if (v < -ONE_P) begin
      return MW'(-ONE_P);
    end
    return MW'(v);
  endfunction

endpackage

/* rtl/core/axis_angle_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix: twist to 3x3 rotation plus translation
// Rodrigues' formula over a pipelined chain of cells: square root, axis
// division, angle reduction, CORDIC cos/sin and matrix assembly.
//
//  channel | dir | transfer payload (tdata, low bits first)
//  --------+-----+------------------------------------------------------------
//  in_     | in  | twist_x, twist_y, twist_z, shift_x, shift_y, shift_z
//  out_    | out | r00..r22 (row major), out_x, out_y, out_z
//
// One twist enters every cycle unless the chain holds; each result passes 77
// register stages (input squares 1, root cells 20, rounding 1, divide cells
// 17, angle reduction 4, CORDIC cells 30, matrix assembly 4) and then shows
// on out_tvalid.
// The whole chain advances together whenever the output register is empty
// or being taken; while out_tready holds low with a result waiting, every
// cell and in_tready hold.
// Synchronous active-low reset clears only the valid bits of the cells.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // twist_x, twist_y, twist_z, shift_x, shift_y, shift_z, zero pad
  input  logic [aa2rm_pkg::IN_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, out_x, out_y, out_z, zero pad
  output logic [aa2rm_pkg::OUT_W-1:0] out_tdata
);

  localparam int TW = aa2rm_pkg::TW;
  localparam int SW = aa2rm_pkg::SW;

  typedef struct packed {
    aa2rm_pkg::side_t                side;
    logic [2:0][aa2rm_pkg::SQ_W-1:0] sq;
  } s0_t;

  logic en;

  s0_t                 s0_r, s0_nxt;
  aa2rm_pkg::sqrt_t    sq_c [0:aa2rm_pkg::NSQ];
  aa2rm_pkg::div_t     th_r, th_nxt;
  aa2rm_pkg::div_t     dv_c [0:aa2rm_pkg::NDIV];
  aa2rm_pkg::ang_t     ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt, rd_r, rd_nxt;
  aa2rm_pkg::cor_t     co_c [0:aa2rm_pkg::NCOR];
  aa2rm_pkg::res_t     res;

  logic signed [2*TW-1:0]            vsq [3];
  logic [aa2rm_pkg::ABS_W-1:0]       vabs [3];
  logic [aa2rm_pkg::ABS_W-1:0]       absum;
  logic [aa2rm_pkg::NUM_W-1:0]       mag [3];
  logic [aa2rm_pkg::AX_W-1:0]        qx [3];

  // advance the whole chain when the output slot frees up
  assign en        = !res.vld || out_tready;
  assign in_tready = en;

  // input stage: unpack, squares, small-angle test
  always_comb begin
    s0_nxt.side.vld  = in_tvalid;
    s0_nxt.side.v[0] = in_tdata[TW-1:0];
    s0_nxt.side.v[1] = in_tdata[2*TW-1:TW];
    s0_nxt.side.v[2] = in_tdata[3*TW-1:2*TW];
    s0_nxt.side.p[0] = in_tdata[3*TW+SW-1:3*TW];
    s0_nxt.side.p[1] = in_tdata[3*TW+2*SW-1:3*TW+SW];
    s0_nxt.side.p[2] = in_tdata[3*TW+3*SW-1:3*TW+2*SW];
    for (int i = 0; i < 3; i++) begin
      vsq[i]       = $signed(s0_nxt.side.v[i]) * $signed(s0_nxt.side.v[i]);
      s0_nxt.sq[i] = aa2rm_pkg::SQ_W'(unsigned'(vsq[i]));
      vabs[i]      = aa2rm_pkg::ABS_W'($signed(s0_nxt.side.v[i]));
      if (vabs[i][aa2rm_pkg::ABS_W-1]) begin
        vabs[i] = -vabs[i];
      end
    end
    absum            = vabs[0] + vabs[1] + vabs[2];
    s0_nxt.side.tiny = absum < aa2rm_pkg::THR;
  end

  // root chain seeds with the sum of squares
  always_comb begin
    sq_c[0].side = s0_r.side;
    sq_c[0].n    = s0_r.sq[0] + s0_r.sq[1] + s0_r.sq[2];
    sq_c[0].r    = '0;
  end

  for (genvar k = 0; k < aa2rm_pkg::NSQ; k++) begin : g_sqrt
    aa2rm_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .bexp  (aa2rm_pkg::SQE_W'(2 * (aa2rm_pkg::NSQ - 1 - k))),
      .d_in  (sq_c[k]),
      .d_out (sq_c[k+1])
    );
  end

  // round the root to nearest
  always_comb begin
    th_nxt       = '0;
    th_nxt.side  = sq_c[aa2rm_pkg::NSQ].side;
    th_nxt.theta = aa2rm_pkg::TH_W'(sq_c[aa2rm_pkg::NSQ].r)
                 + aa2rm_pkg::TH_W'(sq_c[aa2rm_pkg::NSQ].n > sq_c[aa2rm_pkg::NSQ].r);
  end

  // divider seeds: |v| scaled up plus half the divisor for rounding
  always_comb begin
    dv_c[0].side  = th_r.side;
    dv_c[0].theta = th_r.theta;
    for (int i = 0; i < 3; i++) begin
      mag[i] = aa2rm_pkg::NUM_W'($signed(th_r.side.v[i]));
      if (th_r.side.v[i][TW-1]) begin
        mag[i] = -mag[i];
      end
      dv_c[0].rem[i] = (mag[i] << aa2rm_pkg::FRAC_BITS)
                     + aa2rm_pkg::NUM_W'(th_r.theta >> 1);
      dv_c[0].q[i]   = '0;
    end
  end

  for (genvar k = 0; k < aa2rm_pkg::NDIV; k++) begin : g_div
    aa2rm_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .dsh   (aa2rm_pkg::DSH_W'(aa2rm_pkg::NDIV - 1 - k)),
      .d_in  (dv_c[k]),
      .d_out (dv_c[k+1])
    );
  end

  // restore axis signs, angle to Q30, first modulo step
  always_comb begin
    ra_nxt.side = dv_c[aa2rm_pkg::NDIV].side;
    for (int i = 0; i < 3; i++) begin
      qx[i] = aa2rm_pkg::AX_W'(dv_c[aa2rm_pkg::NDIV].q[i]);
      ra_nxt.ax[i] = dv_c[aa2rm_pkg::NDIV].side.v[i][TW-1] ? -qx[i] : qx[i];
    end
    ra_nxt.a    = $signed(aa2rm_pkg::ANG_W'(dv_c[aa2rm_pkg::NDIV].theta))
                  <<< aa2rm_pkg::CS_SH;
    ra_nxt.flip = 1'b0;
    if (ra_nxt.a >= aa2rm_pkg::TWO_PI) begin
      ra_nxt.a = ra_nxt.a - aa2rm_pkg::TWO_PI;
    end
  end

  // second modulo step
  always_comb begin
    rb_nxt = ra_r;
    if (ra_r.a >= aa2rm_pkg::TWO_PI) begin
      rb_nxt.a = ra_r.a - aa2rm_pkg::TWO_PI;
    end
  end

  // wrap into [-pi, pi]
  always_comb begin
    rc_nxt = rb_r;
    if (rb_r.a > aa2rm_pkg::PI_Q30) begin
      rc_nxt.a = rb_r.a - aa2rm_pkg::TWO_PI;
    end
  end

  // fold into [-pi/2, pi/2], remember the sign flip
  always_comb begin
    rd_nxt = rc_r;
    if (rc_r.a > aa2rm_pkg::HALF_PI) begin
      rd_nxt.a    = rc_r.a - aa2rm_pkg::PI_Q30;
      rd_nxt.flip = 1'b1;
    end else if (rc_r.a < -aa2rm_pkg::HALF_PI) begin
      rd_nxt.a    = rc_r.a + aa2rm_pkg::PI_Q30;
      rd_nxt.flip = 1'b1;
    end
  end

  always_comb begin
    co_c[0].side = rd_r.side;
    co_c[0].ax   = rd_r.ax;
    co_c[0].x    = aa2rm_pkg::GAIN;
    co_c[0].y    = '0;
    co_c[0].z    = rd_r.a;
    co_c[0].flip = rd_r.flip;
  end

  for (genvar k = 0; k < aa2rm_pkg::NCOR; k++) begin : g_cordic
    aa2rm_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .sh    (aa2rm_pkg::CSH_W'(k)),
      .atan  (aa2rm_pkg::ATAN[k]),
      .d_in  (co_c[k]),
      .d_out (co_c[k+1])
    );
  end

  aa2rm_mat u_mat (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  (co_c[aa2rm_pkg::NCOR]),
    .d_out (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.side.vld <= 1'b0;
      th_r.side.vld <= 1'b0;
      ra_r.side.vld <= 1'b0;
      rb_r.side.vld <= 1'b0;
      rc_r.side.vld <= 1'b0;
      rd_r.side.vld <= 1'b0;
    end else if (en) begin
      s0_r <= s0_nxt;
      th_r <= th_nxt;
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
      rc_r <= rc_nxt;
      rd_r <= rd_nxt;
    end
  end

  // pack the result transfer
  assign out_tvalid = res.vld;
  assign out_tdata  = {6'b0, res.p[2], res.p[1], res.p[0],
                       res.r[8], res.r[7], res.r[6], res.r[5], res.r[4],
                       res.r[3], res.r[2], res.r[1], res.r[0]};

endmodule

/* rtl/core/aa2rm_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// aa2rm_sqrt_cell: one digit of the integer square root
// Decides one root bit per cell, bit weight set by the exponent input.
// ----------------------------------------------------------------------------
module aa2rm_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [aa2rm_pkg::SQE_W-1:0]  bexp,
  input  aa2rm_pkg::sqrt_t             d_in,
  output aa2rm_pkg::sqrt_t             d_out
);

  aa2rm_pkg::sqrt_t               q_r, q_nxt;
  logic [aa2rm_pkg::SQ_W-1:0]     bitw, trial;

  always_comb begin
    bitw  = aa2rm_pkg::SQ_W'(1) << bexp;
    trial = d_in.r + bitw;
    q_nxt = d_in;
    if (d_in.n >= trial) begin
      q_nxt.n = d_in.n - trial;
      q_nxt.r = (d_in.r >> 1) + bitw;
    end else begin
      q_nxt.r = d_in.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.side.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

/* rtl/core/aa2rm_div_cell.sv */
// ----------------------------------------------------------------------------
// aa2rm_div_cell: one quotient bit of the three axis divisions
// Compare and subtract the shifted angle from each lane's remainder.
// ----------------------------------------------------------------------------
module aa2rm_div_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [aa2rm_pkg::DSH_W-1:0]  dsh,
  input  aa2rm_pkg::div_t              d_in,
  output aa2rm_pkg::div_t              d_out
);

  aa2rm_pkg::div_t            q_r, q_nxt;
  logic [aa2rm_pkg::NUM_W-1:0] dvs;

  always_comb begin
    dvs   = aa2rm_pkg::NUM_W'(d_in.theta) << dsh;
    q_nxt = d_in;
    for (int i = 0; i < 3; i++) begin
      if (d_in.rem[i] >= dvs) begin
        q_nxt.rem[i] = d_in.rem[i] - dvs;
        q_nxt.q[i]   = {d_in.q[i][aa2rm_pkg::Q_W-2:0], 1'b1};
      end else begin
        q_nxt.q[i]   = {d_in.q[i][aa2rm_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.side.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

/* rtl/core/aa2rm_cordic_cell.sv */
// ----------------------------------------------------------------------------
// aa2rm_cordic_cell: one rotation-mode CORDIC step
// Rotate toward zero residual angle by the step's arctangent.
// ----------------------------------------------------------------------------
module aa2rm_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [aa2rm_pkg::CSH_W-1:0]  sh,
  input  logic [31:0]                  atan,
  input  aa2rm_pkg::cor_t              d_in,
  output aa2rm_pkg::cor_t              d_out
);

  aa2rm_pkg::cor_t                    q_r, q_nxt;
  logic signed [aa2rm_pkg::ANG_W-1:0] at;
  logic signed [aa2rm_pkg::XY_W-1:0]  xs, ys;

  always_comb begin
    at    = aa2rm_pkg::ANG_W'($signed({1'b0, atan}));
    xs    = d_in.x >>> sh;
    ys    = d_in.y >>> sh;
    q_nxt = d_in;
    if (d_in.z >= 0) begin
      q_nxt.x = d_in.x - ys;
      q_nxt.y = d_in.y + xs;
      q_nxt.z = d_in.z - at;
    end else begin
      q_nxt.x = d_in.x + ys;
      q_nxt.y = d_in.y - xs;
      q_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.side.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

/* rtl/core/aa2rm_mat.sv */
// ----------------------------------------------------------------------------
// aa2rm_mat: Rodrigues matrix assembly
// Round cos/sin, form the scaled axis products, sum, saturate, register.
// ----------------------------------------------------------------------------
module aa2rm_mat (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  aa2rm_pkg::cor_t  d_in,
  output aa2rm_pkg::res_t  d_out
);

  typedef logic signed [aa2rm_pkg::P_W-1:0] pv_t;

  typedef struct packed {
    aa2rm_pkg::side_t                side;
    logic [2:0][aa2rm_pkg::AX_W-1:0] ax;
    pv_t                             c;
    pv_t                             s;
  } m0_t;

  typedef struct packed {
    aa2rm_pkg::side_t                side;
    logic [2:0][aa2rm_pkg::AX_W-1:0] ax;
    pv_t                             c;
    logic [2:0][aa2rm_pkg::P_W-1:0]  tq;
    logic [2:0][aa2rm_pkg::P_W-1:0]  sa;
  } m1_t;

  typedef struct packed {
    aa2rm_pkg::side_t                side;
    pv_t                             c;
    logic [2:0][aa2rm_pkg::P_W-1:0]  sa;
    logic [5:0][aa2rm_pkg::P_W-1:0]  pp;
  } m2_t;

  m0_t             m0_r, m0_nxt;
  m1_t             m1_r, m1_nxt;
  m2_t             m2_r, m2_nxt;
  aa2rm_pkg::res_t m3_r, m3_nxt;

  logic signed [aa2rm_pkg::XY_W-1:0] xf, yf;
  pv_t  t1;
  pv_t  ax1 [3];
  pv_t  ax2 [3];
  pv_t  rs  [9];
  pv_t  cc, sx, sy, sz;

  // round cos/sin, undo the half-turn fold
  always_comb begin
    xf = d_in.flip ? -d_in.x : d_in.x;
    yf = d_in.flip ? -d_in.y : d_in.y;
    m0_nxt.side = d_in.side;
    m0_nxt.ax   = d_in.ax;
    m0_nxt.c    = aa2rm_pkg::P_W'((xf + (aa2rm_pkg::XY_W'(1) <<< (aa2rm_pkg::CS_SH - 1)))
                                  >>> aa2rm_pkg::CS_SH);
    m0_nxt.s    = aa2rm_pkg::P_W'((yf + (aa2rm_pkg::XY_W'(1) <<< (aa2rm_pkg::CS_SH - 1)))
                                  >>> aa2rm_pkg::CS_SH);
  end

  // first products: t*a and a*s
  always_comb begin
    t1 = aa2rm_pkg::ONE_P - m0_r.c;
    m1_nxt.side = m0_r.side;
    m1_nxt.ax   = m0_r.ax;
    m1_nxt.c    = m0_r.c;
    for (int i = 0; i < 3; i++) begin
      ax1[i]       = aa2rm_pkg::P_W'($signed(m0_r.ax[i]));
      m1_nxt.tq[i] = aa2rm_pkg::mulq(t1, ax1[i]);
      m1_nxt.sa[i] = aa2rm_pkg::mulq(ax1[i], m0_r.s);
    end
  end

  // second products: t*ai*aj
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax2[i] = aa2rm_pkg::P_W'($signed(m1_r.ax[i]));
    end
    m2_nxt.side  = m1_r.side;
    m2_nxt.c     = m1_r.c;
    m2_nxt.sa    = m1_r.sa;
    m2_nxt.pp[0] = aa2rm_pkg::mulq($signed(m1_r.tq[0]), ax2[0]);
    m2_nxt.pp[1] = aa2rm_pkg::mulq($signed(m1_r.tq[0]), ax2[1]);
    m2_nxt.pp[2] = aa2rm_pkg::mulq($signed(m1_r.tq[0]), ax2[2]);
    m2_nxt.pp[3] = aa2rm_pkg::mulq($signed(m1_r.tq[1]), ax2[1]);
    m2_nxt.pp[4] = aa2rm_pkg::mulq($signed(m1_r.tq[1]), ax2[2]);
    m2_nxt.pp[5] = aa2rm_pkg::mulq($signed(m1_r.tq[2]), ax2[2]);
  end

  // sums, saturation, identity for tiny rotations
  always_comb begin
    cc = m2_r.c;
    sx = $signed(m2_r.sa[0]);
    sy = $signed(m2_r.sa[1]);
    sz = $signed(m2_r.sa[2]);
    rs[0] = $signed(m2_r.pp[0]) + cc;
    rs[1] = $signed(m2_r.pp[1]) - sz;
    rs[2] = $signed(m2_r.pp[2]) + sy;
    rs[3] = $signed(m2_r.pp[1]) + sz;
    rs[4] = $signed(m2_r.pp[3]) + cc;
    rs[5] = $signed(m2_r.pp[4]) - sx;
    rs[6] = $signed(m2_r.pp[2]) - sy;
    rs[7] = $signed(m2_r.pp[4]) + sx;
    rs[8] = $signed(m2_r.pp[5]) + cc;
    m3_nxt.vld = m2_r.side.vld;
    m3_nxt.p   = m2_r.side.p;
    for (int k = 0; k < 9; k++) begin
      if (m2_r.side.tiny) begin
        m3_nxt.r[k] = (k % 4 == 0) ? aa2rm_pkg::MW'(aa2rm_pkg::ONE_P) : '0;
      end else begin
        m3_nxt.r[k] = aa2rm_pkg::sat1(rs[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_r.side.vld <= 1'b0;
      m1_r.side.vld <= 1'b0;
      m2_r.side.vld <= 1'b0;
      m3_r.vld      <= 1'b0;
    end else if (en) begin
      m0_r <= m0_nxt;
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
    end
  end

  assign d_out = m3_r;

endmodule

/* rtl/core/aa2rm_chk.sv */
// ----------------------------------------------------------------------------
// aa2rm_chk: port-level checks for the rotation pipeline
// Watches in_tready and the output channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module aa2rm_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tready,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [aa2rm_pkg::OUT_W-1:0] out_tdata
);

  localparam logic signed [17:0] P1 = 18'sd65536;
  localparam logic signed [17:0] M1 = -18'sd65536;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // an empty output slot never blocks input
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // diagonal entries stay within one
  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[17:0]) <= P1 && $signed(out_tdata[17:0]) >= M1
      && $signed(out_tdata[89:72]) <= P1 && $signed(out_tdata[89:72]) >= M1
      && $signed(out_tdata[161:144]) <= P1 && $signed(out_tdata[161:144]) >= M1)
    else $error("diagonal entry out of range");

  // padding stays zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[aa2rm_pkg::OUT_W-1:234] == '0)
    else $error("nonzero padding");

endmodule

bind axis_angle_to_rotation_matrix aa2rm_chk u_aa2rm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/axis_angle_to_rotation_matrix_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_tb: self-checking bench for the twist block
// Streams twists through the block with random gaps and output stalls. A
// directed table covers the identity cases, the field extremes, sign mixes
// and saturating rotations, then random twists follow, mostly of moderate
// size with some full-range and near-threshold ones. Every result is checked
// field by field against a bit-exact fixed-point predictor or a typed-in identity.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_matrix_tb;

  localparam int TW        = aa2rm_pkg::TW;
  localparam int SW        = aa2rm_pkg::SW;
  localparam int MW        = aa2rm_pkg::MW;
  localparam int IN_W      = aa2rm_pkg::IN_W;
  localparam int OUT_W     = aa2rm_pkg::OUT_W;
  localparam int FRAC_BITS = aa2rm_pkg::FRAC_BITS;
  localparam int ONE_I     = aa2rm_pkg::ONE_I;
  localparam int THR_I     = aa2rm_pkg::THR_I;

  localparam int N_RANDOM    = 750;
  localparam int LATENCY     = 77;
  localparam longint CYC_MAX = 400000;

  // Q30 constants of the angle reduction and the CORDIC
  localparam longint Q30_2PI  = 64'sd6746518852;
  localparam longint Q30_PI   = 64'sd3373259426;
  localparam longint Q30_HPI  = 64'sd1686629713;
  localparam longint CGAIN    = 64'sd652032874;

  typedef struct {
    logic signed [TW-1:0] tw [3];
    logic signed [SW-1:0] sh [3];
  } twist_t;

  typedef struct {
    logic signed [MW-1:0] m [9];
    logic signed [SW-1:0] t [3];
    bit                   fixed;   // typed-in expectation from the table
  } pose_t;

  typedef struct {
    twist_t tw;
    bit     has_exp;
    pose_t  exp;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  pose_t  pending_poses[$];
  row_t   dir_rows[$];
  int     n_errors = 0;
  int     n_results = 0;
  int     n_sent = 0;
  longint cycle = 0;
  bit     stim_done = 1'b0;

  longint atan_tab [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  axis_angle_to_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // rounding fixed-point product, arithmetic shift
  function automatic longint fx_mul(longint a, longint b);
    return (a * b + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > ONE_I) return ONE_I;
    if (v < -ONE_I) return -ONE_I;
    return v;
  endfunction

  // integer square root, rounded to nearest
  function automatic longint root_round(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  function automatic longint unit_axis(longint v, longint theta);
    longint mag, q;
    mag = (v < 0 ? -v : v) << FRAC_BITS;
    q = (mag + theta / 2) / theta;
    return v < 0 ? -q : q;
  endfunction

  function automatic pose_t rodrigues(twist_t tw);
    pose_t  p;
    longint v [3];
    longint ax [3];
    longint r [9];
    longint absum, theta, a, x, y, nx, c, s, t, txy, txz, tyz;
    bit     flip;
    absum = 0;
    for (int k = 0; k < 3; k++) begin
      v[k] = tw.tw[k];
      absum += v[k] < 0 ? -v[k] : v[k];
    end
    if (absum < THR_I) begin
      foreach (r[k]) r[k] = 0;
      r[0] = ONE_I; r[4] = ONE_I; r[8] = ONE_I;
    end else begin
      theta = root_round(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
      for (int k = 0; k < 3; k++) ax[k] = unit_axis(v[k], theta);
      a = theta << (30 - FRAC_BITS);
      a = a % Q30_2PI;
      flip = 1'b0;
      if (a > Q30_PI) a -= Q30_2PI;
      if (a > Q30_HPI) begin
        a -= Q30_PI; flip = 1'b1;
      end else if (a < -Q30_HPI) begin
        a += Q30_PI; flip = 1'b1;
      end
      x = CGAIN;
      y = 0;
      for (int i = 0; i < 30; i++) begin
        if (a >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); a -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); a += atan_tab[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = (x + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      s = (y + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      t = ONE_I - c;
      txy = fx_mul(fx_mul(t, ax[0]), ax[1]);
      txz = fx_mul(fx_mul(t, ax[0]), ax[2]);
      tyz = fx_mul(fx_mul(t, ax[1]), ax[2]);
      r[0] = fx_mul(fx_mul(t, ax[0]), ax[0]) + c;
      r[1] = txy - fx_mul(ax[2], s);
      r[2] = txz + fx_mul(ax[1], s);
      r[3] = txy + fx_mul(ax[2], s);
      r[4] = fx_mul(fx_mul(t, ax[1]), ax[1]) + c;
      r[5] = tyz - fx_mul(ax[0], s);
      r[6] = txz - fx_mul(ax[1], s);
      r[7] = tyz + fx_mul(ax[0], s);
      r[8] = fx_mul(fx_mul(t, ax[2]), ax[2]) + c;
    end
    for (int k = 0; k < 9; k++) p.m[k] = MW'(clip_unit(r[k]));
    for (int k = 0; k < 3; k++) p.t[k] = tw.sh[k];
    p.fixed = 1'b0;
    return p;
  endfunction

  function automatic twist_t make_twist(int x, int y, int z, int px, int py, int pz);
    twist_t tw;
    tw.tw[0] = TW'(x); tw.tw[1] = TW'(y); tw.tw[2] = TW'(z);
    tw.sh[0] = SW'(px); tw.sh[1] = SW'(py); tw.sh[2] = SW'(pz);
    return tw;
  endfunction

  function automatic pose_t identity_pose(twist_t tw);
    pose_t p;
    for (int k = 0; k < 9; k++) p.m[k] = (k % 4 == 0) ? MW'(ONE_I) : '0;
    for (int k = 0; k < 3; k++) p.t[k] = tw.sh[k];
    p.fixed = 1'b1;
    return p;
  endfunction

  // mostly moderate angles, some full range, some around the threshold
  function automatic twist_t random_twist();
    twist_t tw;
    int     pick;
    pick = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (pick < 6) tw.tw[k] = TW'($urandom_range(0, 2 * 262144) - 262144);
      else if (pick < 8) tw.tw[k] = TW'($urandom());
      else tw.tw[k] = TW'($urandom_range(0, 8) - 4);
      tw.sh[k] = SW'($urandom());
    end
    return tw;
  endfunction

  task automatic add_row(twist_t tw, bit typed);
    row_t row;
    row.tw = tw;
    row.has_exp = typed;
    if (typed) row.exp = identity_pose(tw);
    dir_rows.push_back(row);
  endtask

  // send one twist: random gap with valid low, then hold valid until the transfer
  task automatic send_twist(twist_t tw, pose_t exp);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {4'b0, tw.sh[2], tw.sh[1], tw.sh[0], tw.tw[2], tw.tw[1], tw.tw[0]};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_poses.push_back(exp);
    n_sent++;
  endtask

  // receive side: random stall per result, compare with the oldest pose
  initial begin : result_check
    pose_t exp;
    logic signed [MW-1:0] got_m;
    logic signed [SW-1:0] got_t;
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      n_results++;
      if (pending_poses.size() == 0) begin
        $error("result with no twist outstanding");
        n_errors++;
      end else begin
        exp = pending_poses.pop_front();
        for (int k = 0; k < 9; k++) begin
          got_m = out_tdata[k*MW +: MW];
          if (got_m !== exp.m[k]) begin
            $error("r%0d%0d expected %0d actual %0d", k / 3, k % 3, exp.m[k], got_m);
            n_errors++;
          end
        end
        for (int k = 0; k < 3; k++) begin
          got_t = out_tdata[9*MW + k*SW +: SW];
          if (got_t !== exp.t[k]) begin
            $error("out_%s expected %0d actual %0d", k == 0 ? "x" : (k == 1 ? "y" : "z"),
                   exp.t[k], got_t);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYC_MAX) begin
      $display("timeout after %0d cycles", cycle);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    twist_t tw;
    pose_t  exp;
    int     idle;
    // identity cases: zero vector, sums just under the threshold
    add_row(make_twist(0, 0, 0, 0, 0, 0), 1'b1);
    add_row(make_twist(THR_I - 1, 0, 0, 8388607, -8388608, 1), 1'b1);
    add_row(make_twist(-2, 2, -2, -1, 0, 8388607), 1'b1);
    add_row(make_twist(0, 0, -(THR_I - 1), 123456, -654321, -8388608), 1'b1);
    // at the threshold, on one axis and spread over three
    add_row(make_twist(THR_I, 0, 0, 5, 6, 7), 1'b0);
    add_row(make_twist(3, -2, 2, 0, 0, 0), 1'b0);
    // field extremes
    add_row(make_twist(524287, 524287, 524287, 8388607, 8388607, 8388607), 1'b0);
    add_row(make_twist(-524288, -524288, -524288, -8388608, -8388608, -8388608), 1'b0);
    add_row(make_twist(524287, -524288, 0, -1, 1, -1), 1'b0);
    add_row(make_twist(0, 0, -524288, 0, 0, 0), 1'b0);
    // single-axis quarter, half and full turns (entries that round to +-1), then mixed axes
    add_row(make_twist(102944, 0, 0, 0, 0, 0), 1'b0);
    add_row(make_twist(0, 205887, 0, 0, 0, 0), 1'b0);
    add_row(make_twist(0, 0, -205887, 0, 0, 0), 1'b0);
    add_row(make_twist(0, 0, 411775, 0, 0, 0), 1'b0);
    add_row(make_twist(-102944, 0, 0, 0, 0, 0), 1'b0);
    add_row(make_twist(65536, 65536, 65536, 65536, -65536, 0), 1'b0);
    add_row(make_twist(-65536, 65536, -65536, 0, 0, 0), 1'b0);
    add_row(make_twist(300000, -300000, 300000, 0, 0, 0), 1'b0);

    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      exp = dir_rows[i].has_exp ? dir_rows[i].exp : rodrigues(dir_rows[i].tw);
      send_twist(dir_rows[i].tw, exp);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      // hold the sender until the pipeline has drained, now and then
      if (i == N_RANDOM / 2 || $urandom_range(0, 199) == 0) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_poses.size() != 0) @(posedge clk);
      end
      // run bursts back to back so the pipeline fills
      tw = random_twist();
      if (i >= 100 && i < 200) begin
        in_tdata <= {4'b0, tw.sh[2], tw.sh[1], tw.sh[0], tw.tw[2], tw.tw[1], tw.tw[0]};
        in_tvalid <= 1'b1;
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        pending_poses.push_back(rodrigues(tw));
        n_sent++;
      end else begin
        send_twist(tw, rodrigues(tw));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
    idle = 0;
    while (idle < 2 * LATENCY) begin
      @(posedge clk);
      idle++;
    end
    $display("sent %0d twists (%0d table rows, rest random), checked %0d results",
             n_sent, dir_rows.size(), n_results);
    $display("identity, threshold, extreme, turn and saturation cases under random gaps");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
